@@ rtl/core/tbin_pkg.sv @@
// ----------------------------------------------------------------------------
// tbin_pkg : shared types and constants for the triangle tile binner
// Field widths, configuration register indexes, sequencer states and the
// structs that pass between the binner's modules.
// ----------------------------------------------------------------------------
package tbin_pkg;

    localparam int COORD_W   = 20;   // s15.4 vertex coordinate
    localparam int TAG_W     = 16;
    localparam int IDX_W     = 4;    // tile index, wraps modulo 16
    localparam int CFG_W     = 12;
    localparam int CFG_IDX_W = 3;
    localparam int BOX_W     = 17;   // whole-pixel box edge, signed
    localparam int DIVD_W    = 16;   // divider dividend and quotient
    localparam int SPAN_W    = 5;    // tile coordinate, 0 to 16
    localparam int MAX_RESULTS = 16;

    localparam int TILES_X_DEF = 4;
    localparam int TILES_Y_DEF = 4;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_SCISSOR_ENABLE = 3'd0,
        CFG_SCISSOR_MIN_X  = 3'd1,
        CFG_SCISSOR_MIN_Y  = 3'd2,
        CFG_SCISSOR_MAX_X  = 3'd3,
        CFG_SCISSOR_MAX_Y  = 3'd4,
        CFG_TILE_WIDTH     = 3'd5,
        CFG_TILE_HEIGHT    = 3'd6
    } cfg_idx_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CLIP,
        ST_TEST,
        ST_DIV_START,
        ST_DIV_WAIT,
        ST_EMIT_START,
        ST_EMIT
    } state_t;

    typedef enum logic [1:0] {
        JOB_SX = 2'd0,
        JOB_EX = 2'd1,
        JOB_SY = 2'd2,
        JOB_EY = 2'd3
    } div_job_t;

    typedef struct packed {
        logic [SPAN_W-1:0] sx;
        logic [SPAN_W-1:0] ex;
        logic [SPAN_W-1:0] sy;
        logic [SPAN_W-1:0] ey;
    } span_t;

    typedef struct packed {
        logic              start;
        logic [DIVD_W-1:0] dividend;
        logic [CFG_W-1:0]  divisor;
    } div_req_t;

    typedef struct packed {
        logic             start;
        span_t            span;
        logic [TAG_W-1:0] tag;
    } emit_cmd_t;

endpackage

@@ rtl/core/tbin_div.sv @@
// ----------------------------------------------------------------------------
// tbin_div : shared restoring divider
// Unsigned 16-bit by 12-bit division, one quotient bit per cycle. Pulses
// done for one cycle once the quotient is complete.
// ----------------------------------------------------------------------------
module tbin_div
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  tbin_pkg::div_req_t        req,
    output logic                      done,
    output logic [tbin_pkg::DIVD_W-1:0] quotient
);
    import tbin_pkg::*;

    localparam int CNT_W = $clog2(DIVD_W);

    logic                busy_reg;
    logic                done_reg;
    logic [CNT_W-1:0]    cnt_reg;
    logic [CFG_W-1:0]    rem_reg;
    logic [DIVD_W-1:0]   quo_reg;
    logic [CFG_W-1:0]    dsr_reg;

    logic [CFG_W:0]      trial;
    logic [CFG_W:0]      diff;
    logic                ge;
    logic [CFG_W-1:0]    rem_next;
    logic [DIVD_W-1:0]   quo_next;

    // quo_reg shifts the dividend out at the top and the quotient in at the bottom
    always_comb
    begin
        trial    = {rem_reg, quo_reg[DIVD_W-1]};
        ge       = (trial >= {1'b0, dsr_reg});
        diff     = trial - {1'b0, dsr_reg};
        rem_next = ge ? diff[CFG_W-1:0] : trial[CFG_W-1:0];
        quo_next = {quo_reg[DIVD_W-2:0], ge};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (req.start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end
            else if (busy_reg)
            begin
                cnt_reg <= CNT_W'(cnt_reg + 1'b1);
                if (cnt_reg == CNT_W'(DIVD_W - 1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (req.start)
        begin
            rem_reg <= '0;
            quo_reg <= req.dividend;
            dsr_reg <= req.divisor;
        end
        else if (busy_reg)
        begin
            rem_reg <= rem_next;
            quo_reg <= quo_next;
        end
    end

    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule

@@ rtl/core/tbin_emit.sv @@
// ----------------------------------------------------------------------------
// tbin_emit : tile walker
// Steps through the tile span in row-major order, one output word per
// accepted handshake, capped at sixteen words, flagging the last one.
// ----------------------------------------------------------------------------
module tbin_emit
#(
    parameter int TILES_X = tbin_pkg::TILES_X_DEF
)
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  tbin_pkg::emit_cmd_t          cmd,
    output logic                         done,
    output logic                         out_valid,
    input  logic                         out_ready,
    output logic [tbin_pkg::IDX_W-1:0]   tile_index,
    output logic [tbin_pkg::TAG_W-1:0]   tri_tag,
    output logic                         last_tile
);
    import tbin_pkg::*;

    localparam logic [IDX_W-1:0] STRIDE = IDX_W'(TILES_X);

    logic                busy_reg;
    logic                done_reg;
    logic [IDX_W-1:0]    cnt_reg;
    logic [SPAN_W-1:0]   tx_reg;
    logic [SPAN_W-1:0]   ty_reg;
    logic [IDX_W-1:0]    base_reg;
    span_t               span_reg;
    logic [TAG_W-1:0]    tag_reg;

    logic                empty;
    logic                row_end;
    logic                col_end;
    logic                last;
    logic                fire;

    always_comb
    begin
        empty   = (cmd.span.sx >= cmd.span.ex) || (cmd.span.sy >= cmd.span.ey);
        row_end = (SPAN_W'(tx_reg + 1'b1) == span_reg.ex);
        col_end = (SPAN_W'(ty_reg + 1'b1) == span_reg.ey);
        last    = (cnt_reg == IDX_W'(MAX_RESULTS - 1)) || (row_end && col_end);
        fire    = busy_reg && out_ready;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (cmd.start)
            begin
                cnt_reg <= '0;
                if (empty)
                begin
                    done_reg <= 1'b1;
                end
                else
                begin
                    busy_reg <= 1'b1;
                end
            end
            else if (fire)
            begin
                cnt_reg <= IDX_W'(cnt_reg + 1'b1);
                if (last)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    // base_reg tracks ty * TILES_X modulo 16
    always_ff @(posedge clk)
    begin
        if (cmd.start)
        begin
            tx_reg   <= cmd.span.sx;
            ty_reg   <= cmd.span.sy;
            base_reg <= IDX_W'(cmd.span.sy[IDX_W-1:0] * STRIDE);
            span_reg <= cmd.span;
            tag_reg  <= cmd.tag;
        end
        else if (fire && !last)
        begin
            if (row_end)
            begin
                tx_reg   <= span_reg.sx;
                ty_reg   <= SPAN_W'(ty_reg + 1'b1);
                base_reg <= IDX_W'(base_reg + STRIDE);
            end
            else
            begin
                tx_reg <= SPAN_W'(tx_reg + 1'b1);
            end
        end
    end

    assign done       = done_reg;
    assign out_valid  = busy_reg;
    assign tile_index = IDX_W'(tx_reg[IDX_W-1:0] + base_reg);
    assign tri_tag    = tag_reg;
    assign last_tile  = last;

    property p_last_ends;
        @(posedge clk) disable iff (!rst_n)
        out_valid && out_ready && last_tile |=> !out_valid;
    endproperty
    a_last_ends: assert property (p_last_ends)
        else $error("tbin_emit: word after last tile");

endmodule

@@ rtl/core/triangle_tile_binner.sv @@
// ----------------------------------------------------------------------------
// triangle_tile_binner : bounding-box tile binning of triangles
// Takes one triangle, forms its whole-pixel bounding box, clips it to the
// scissor rectangle, converts it to a tile span and lists the covered tiles.
//
//   channel | handshake              | payload
//   --------+------------------------+-------------------------------------
//   in      | in_valid / in_ready    | triangle_id, vx0..vx2, vy0..vy2
//   out     | out_valid / out_ready  | tile_index, tri_tag, last_tile
//   cfg     | cfg_we                 | cfg_index, cfg_data
//
// From acceptance to next acceptance, a triangle passes through the accept
// in idle, clip and test, four divisions (start, 16 steps, hand-back) of box
// edges by tile size on the single shared divider, walker start, one word per
// tile, then the walker's done pulse. A box empty after clipping returns to idle.
// in_ready is high only while idle. A stalled output holds the walker on the
// current tile. Reset restores the configuration registers to their defaults.
// ----------------------------------------------------------------------------
module triangle_tile_binner
#(
    parameter int TILES_X = tbin_pkg::TILES_X_DEF,
    parameter int TILES_Y = tbin_pkg::TILES_Y_DEF
)
(
    input  logic                                 clk,
    input  logic                                 rst_n,

    input  logic                                 in_valid,
    output logic                                 in_ready,
    input  logic [tbin_pkg::TAG_W-1:0]           triangle_id,
    input  logic signed [tbin_pkg::COORD_W-1:0]  vx0,
    input  logic signed [tbin_pkg::COORD_W-1:0]  vy0,
    input  logic signed [tbin_pkg::COORD_W-1:0]  vx1,
    input  logic signed [tbin_pkg::COORD_W-1:0]  vy1,
    input  logic signed [tbin_pkg::COORD_W-1:0]  vx2,
    input  logic signed [tbin_pkg::COORD_W-1:0]  vy2,

    output logic                                 out_valid,
    input  logic                                 out_ready,
    output logic [tbin_pkg::IDX_W-1:0]           tile_index,
    output logic [tbin_pkg::TAG_W-1:0]           tri_tag,
    output logic                                 last_tile,

    input  logic                                 cfg_we,
    input  logic [tbin_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [tbin_pkg::CFG_W-1:0]           cfg_data
);
    import tbin_pkg::*;

    // ceil(v / 16) of an s15.4 value: floor((v + 15) / 16)
    function automatic logic signed [BOX_W-1:0] pix_ceil(
        input logic signed [COORD_W-1:0] v);
        logic signed [COORD_W:0] s;
        begin
            s = {v[COORD_W-1], v} + (COORD_W+1)'(15);
            pix_ceil = s[COORD_W:4];
        end
    endfunction

    // configuration
    logic               sc_en_reg;
    logic [CFG_W-1:0]   sc_min_x_reg;
    logic [CFG_W-1:0]   sc_min_y_reg;
    logic [CFG_W-1:0]   sc_max_x_reg;
    logic [CFG_W-1:0]   sc_max_y_reg;
    logic [CFG_W-1:0]   tile_w_reg;
    logic [CFG_W-1:0]   tile_h_reg;

    // sequencer
    state_t             state_reg;
    state_t             state_next;
    div_job_t           job_reg;

    logic signed [BOX_W-1:0] min_x_reg;
    logic signed [BOX_W-1:0] max_x_reg;
    logic signed [BOX_W-1:0] min_y_reg;
    logic signed [BOX_W-1:0] max_y_reg;
    logic [TAG_W-1:0]   tag_reg;
    span_t              span_reg;

    logic signed [COORD_W-1:0] mn_x01;
    logic signed [COORD_W-1:0] mx_x01;
    logic signed [COORD_W-1:0] mn_y01;
    logic signed [COORD_W-1:0] mx_y01;
    logic signed [COORD_W-1:0] mn_x;
    logic signed [COORD_W-1:0] mx_x;
    logic signed [COORD_W-1:0] mn_y;
    logic signed [COORD_W-1:0] mx_y;

    logic signed [BOX_W-1:0] sc_min_x_s;
    logic signed [BOX_W-1:0] sc_min_y_s;
    logic signed [BOX_W-1:0] sc_max_x_s;
    logic signed [BOX_W-1:0] sc_max_y_s;

    logic [CFG_W-1:0]   tw_eff;
    logic [CFG_W-1:0]   th_eff;
    logic               box_empty;
    logic               in_fire;

    div_req_t           div_req;
    logic               div_done;
    logic [DIVD_W-1:0]  div_q;
    logic [SPAN_W-1:0]  sat_x;
    logic [SPAN_W-1:0]  sat_y;

    emit_cmd_t          emit_cmd;
    logic               emit_done;

    // ---------------- configuration registers ----------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sc_en_reg    <= 1'b0;
            sc_min_x_reg <= '0;
            sc_min_y_reg <= '0;
            sc_max_x_reg <= CFG_W'(4095);
            sc_max_y_reg <= CFG_W'(4095);
            tile_w_reg   <= CFG_W'(64);
            tile_h_reg   <= CFG_W'(64);
        end
        else if (cfg_we)
        begin
            case (cfg_idx_t'(cfg_index))
                CFG_SCISSOR_ENABLE: sc_en_reg    <= cfg_data[0];
                CFG_SCISSOR_MIN_X:  sc_min_x_reg <= cfg_data;
                CFG_SCISSOR_MIN_Y:  sc_min_y_reg <= cfg_data;
                CFG_SCISSOR_MAX_X:  sc_max_x_reg <= cfg_data;
                CFG_SCISSOR_MAX_Y:  sc_max_y_reg <= cfg_data;
                CFG_TILE_WIDTH:     tile_w_reg   <= cfg_data;
                CFG_TILE_HEIGHT:    tile_h_reg   <= cfg_data;
                default: ;
            endcase
        end
    end

    // ---------------- bounding box front end ----------------
    always_comb
    begin
        mn_x01 = (vx0 < vx1) ? vx0 : vx1;
        mx_x01 = (vx0 > vx1) ? vx0 : vx1;
        mn_y01 = (vy0 < vy1) ? vy0 : vy1;
        mx_y01 = (vy0 > vy1) ? vy0 : vy1;
        mn_x   = (mn_x01 < vx2) ? mn_x01 : vx2;
        mx_x   = (mx_x01 > vx2) ? mx_x01 : vx2;
        mn_y   = (mn_y01 < vy2) ? mn_y01 : vy2;
        mx_y   = (mx_y01 > vy2) ? mx_y01 : vy2;

        sc_min_x_s = $signed({{(BOX_W-CFG_W){1'b0}}, sc_min_x_reg});
        sc_min_y_s = $signed({{(BOX_W-CFG_W){1'b0}}, sc_min_y_reg});
        sc_max_x_s = $signed({{(BOX_W-CFG_W){1'b0}}, sc_max_x_reg});
        sc_max_y_s = $signed({{(BOX_W-CFG_W){1'b0}}, sc_max_y_reg});

        tw_eff = (tile_w_reg == '0) ? CFG_W'(1) : tile_w_reg;
        th_eff = (tile_h_reg == '0) ? CFG_W'(1) : tile_h_reg;

        box_empty = (min_x_reg >= max_x_reg) || (min_y_reg >= max_y_reg);
        in_fire   = in_valid && in_ready;
    end

    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            min_x_reg <= pix_ceil(mn_x);
            max_x_reg <= pix_ceil(mx_x);
            min_y_reg <= pix_ceil(mn_y);
            max_y_reg <= pix_ceil(mx_y);
            tag_reg   <= triangle_id;
        end
        else if (state_reg == ST_CLIP && sc_en_reg)
        begin
            if (min_x_reg < sc_min_x_s) min_x_reg <= sc_min_x_s;
            if (max_x_reg > sc_max_x_s) max_x_reg <= sc_max_x_s;
            if (min_y_reg < sc_min_y_s) min_y_reg <= sc_min_y_s;
            if (max_y_reg > sc_max_y_s) max_y_reg <= sc_max_y_s;
        end
    end

    // ---------------- divider jobs ----------------
    // negative start or non-positive end divides zero, giving tile 0
    always_comb
    begin
        div_req.start = (state_reg == ST_DIV_START);
        case (job_reg)
            JOB_SX:
            begin
                div_req.dividend = min_x_reg[BOX_W-1] ? '0 : min_x_reg[DIVD_W-1:0];
                div_req.divisor  = tw_eff;
            end
            JOB_EX:
            begin
                div_req.dividend = (max_x_reg[BOX_W-1] || max_x_reg == '0) ? '0 :
                    DIVD_W'(max_x_reg[DIVD_W-1:0] + DIVD_W'(tw_eff - 1'b1));
                div_req.divisor  = tw_eff;
            end
            JOB_SY:
            begin
                div_req.dividend = min_y_reg[BOX_W-1] ? '0 : min_y_reg[DIVD_W-1:0];
                div_req.divisor  = th_eff;
            end
            JOB_EY:
            begin
                div_req.dividend = (max_y_reg[BOX_W-1] || max_y_reg == '0) ? '0 :
                    DIVD_W'(max_y_reg[DIVD_W-1:0] + DIVD_W'(th_eff - 1'b1));
                div_req.divisor  = th_eff;
            end
            default:
            begin
                div_req.dividend = '0;
                div_req.divisor  = tw_eff;
            end
        endcase

        // quotients past the grid saturate at its edge
        sat_x = (div_q > DIVD_W'(TILES_X)) ? SPAN_W'(TILES_X) : div_q[SPAN_W-1:0];
        sat_y = (div_q > DIVD_W'(TILES_Y)) ? SPAN_W'(TILES_Y) : div_q[SPAN_W-1:0];
    end

    tbin_div u_div
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .req      (div_req),
        .done     (div_done),
        .quotient (div_q)
    );

    always_ff @(posedge clk)
    begin
        if (state_reg == ST_DIV_WAIT && div_done)
        begin
            case (job_reg)
                JOB_SX:  span_reg.sx <= sat_x;
                JOB_EX:  span_reg.ex <= sat_x;
                JOB_SY:  span_reg.sy <= sat_y;
                JOB_EY:  span_reg.ey <= sat_y;
                default: ;
            endcase
        end
    end

    // ---------------- sequencer ----------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            job_reg   <= JOB_SX;
        end
        else
        begin
            state_reg <= state_next;
            if (state_reg == ST_TEST)
            begin
                job_reg <= JOB_SX;
            end
            else if (state_reg == ST_DIV_WAIT && div_done)
            begin
                job_reg <= div_job_t'(job_reg + 1'b1);
            end
        end
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:       if (in_valid) state_next = ST_CLIP;
            ST_CLIP:       state_next = ST_TEST;
            ST_TEST:       state_next = box_empty ? ST_IDLE : ST_DIV_START;
            ST_DIV_START:  state_next = ST_DIV_WAIT;
            ST_DIV_WAIT:
            begin
                if (div_done)
                begin
                    state_next = (job_reg == JOB_EY) ? ST_EMIT_START : ST_DIV_START;
                end
            end
            ST_EMIT_START: state_next = ST_EMIT;
            ST_EMIT:       if (emit_done) state_next = ST_IDLE;
            default:       state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        in_ready       = (state_reg == ST_IDLE);
        emit_cmd.start = (state_reg == ST_EMIT_START);
        emit_cmd.span  = span_reg;
        emit_cmd.tag   = tag_reg;
    end

    tbin_emit #(.TILES_X(TILES_X)) u_emit
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (emit_cmd),
        .done       (emit_done),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .tile_index (tile_index),
        .tri_tag    (tri_tag),
        .last_tile  (last_tile)
    );

    // ---------------- checks ----------------
    property p_one_at_a_time;
        @(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready;
    endproperty
    a_one_at_a_time: assert property (p_one_at_a_time)
        else $error("binner: second triangle taken while busy");

    property p_out_in_emit;
        @(posedge clk) disable iff (!rst_n)
        out_valid |-> (state_reg == ST_EMIT);
    endproperty
    a_out_in_emit: assert property (p_out_in_emit)
        else $error("binner: output word outside emit phase");

    property p_div_done_waited;
        @(posedge clk) disable iff (!rst_n)
        div_done |-> (state_reg == ST_DIV_WAIT);
    endproperty
    a_div_done_waited: assert property (p_div_done_waited)
        else $error("binner: divider result not awaited");

    property p_empty_box_idle;
        @(posedge clk) disable iff (!rst_n)
        (state_reg == ST_TEST) && box_empty |=> in_ready;
    endproperty
    a_empty_box_idle: assert property (p_empty_box_idle)
        else $error("binner: empty box did not return to idle");

endmodule
